// File: hw/rtl/wae_pkg.sv
package wae_pkg;

    // Default sizes of the window store and the sample path
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int WL_W       = 7;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DISTURBANCE_COUNT = CFG_IDX_W'(3);

    localparam logic [WL_W-1:0]  WINDOW_LENGTH_RST     = WL_W'(8);
    localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST     = CNT_W'(1);
    localparam logic [CNT_W-1:0] STATE_COUNT_RST       = CNT_W'(1);
    localparam logic [CNT_W-1:0] DISTURBANCE_COUNT_RST = CNT_W'(0);

    // Entries of each queue between front, back and output
    localparam int QUEUE_DEPTH = 2;

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_ACCUM,
        BK_DIV,
        BK_EMIT
    } t_back_state;

    // Channel index width for a given channel count
    function automatic int ch_width(input int max_ch);
        return (max_ch > 1) ? $clog2(max_ch) : 1;
    endfunction

    // Width of one classified item travelling from front to back
    function automatic int item_width(input int sw, input int max_ch, input int win_max);
        return sw + ch_width(max_ch) + $clog2(win_max) + $clog2(win_max + 1) + 4;
    endfunction

endpackage

// File: hw/rtl/wae_fifo.sv
module wae_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wae_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_QW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/wae_front.sv
module wae_front #(
    parameter int WINDOW_MAX   = wae_pkg::WINDOW_MAX_DEF,
    parameter int MAX_CHANNELS = wae_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = wae_pkg::SAMPLE_WIDTH_DEF,
    parameter int ITEM_W       = wae_pkg::item_width(wae_pkg::SAMPLE_WIDTH_DEF,
                                     wae_pkg::MAX_CHANNELS_DEF, wae_pkg::WINDOW_MAX_DEF)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wae_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_push,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    output logic                              o_full,
    input  logic                              i_item_full,
    output logic                              o_item_push,
    output logic [ITEM_W-1:0]                 o_item,
    output logic                              o_clear
);
    import wae_pkg::*;

    localparam int CH_W   = ch_width(MAX_CHANNELS);
    localparam int POS_W  = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int WLC_W  = (LEN_W > WL_W) ? LEN_W : WL_W;
    localparam int NCC_W  = (NCH_W > CNT_W) ? NCH_W : CNT_W;
    localparam int CMP_W  = (CH_W > CNT_W) ? CH_W : CNT_W;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [CH_W-1:0]                ch;
        logic [POS_W-1:0]               pos;
        logic [LEN_W-1:0]               len;
        logic                           state_v;
        logic                           dist_v;
        logic                           last;
        logic                           old_valid;
    } t_item;

    logic [WL_W-1:0]  r_window_length;
    logic [CNT_W-1:0] r_channel_count;
    logic [CNT_W-1:0] r_state_count;
    logic [CNT_W-1:0] r_dist_count;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_wrapped, n_wrapped;

    logic [LEN_W-1:0] len_eff;
    logic [NCH_W-1:0] nch_eff;
    logic             cfg_wr;
    logic             accept;
    logic             last;
    t_item            item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_full      = i_item_full;
    assign accept      = i_push & ~i_item_full;
    assign o_item_push = accept;
    assign o_clear     = cfg_wr && ((i_cfg_index == REG_WINDOW_LENGTH) ||
                                    (i_cfg_index == REG_CHANNEL_COUNT));

    // Clamp window length and channel count to their usable ranges
    always_comb begin
        if (WLC_W'(r_window_length) < WLC_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (WLC_W'(r_window_length) > WLC_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = LEN_W'(r_window_length);
        end
        if (r_channel_count == '0) begin
            nch_eff = NCH_W'(1);
        end else if (NCC_W'(r_channel_count) > NCC_W'(MAX_CHANNELS)) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = NCH_W'(r_channel_count);
        end
    end

    // Classify the sample by channel and window slot
    always_comb begin
        last           = (NCH_W'(r_ch) + NCH_W'(1) == nch_eff);
        item.sample    = i_sample;
        item.ch        = r_ch;
        item.pos       = r_pos;
        item.len       = len_eff;
        item.state_v   = CMP_W'(r_ch) < CMP_W'(r_state_count);
        item.dist_v    = item.state_v && (CMP_W'(r_ch) < CMP_W'(r_dist_count));
        item.last      = last;
        item.old_valid = r_wrapped;
        o_item         = item;
    end

    // Restart the window on a geometry change, else advance channel, then
    // window position after the last channel
    always_comb begin
        n_ch      = r_ch;
        n_pos     = r_pos;
        n_wrapped = r_wrapped;
        if (o_clear) begin
            n_ch      = '0;
            n_pos     = '0;
            n_wrapped = 1'b0;
        end else if (accept) begin
            if (last) begin
                n_ch = '0;
                if (LEN_W'(r_pos) + LEN_W'(1) >= len_eff) begin
                    n_pos     = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end else begin
                n_ch = r_ch + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
            r_state_count   <= STATE_COUNT_RST;
            r_dist_count    <= DISTURBANCE_COUNT_RST;
            r_ch            <= '0;
            r_pos           <= '0;
            r_wrapped       <= 1'b0;
        end else begin
            r_ch      <= n_ch;
            r_pos     <= n_pos;
            r_wrapped <= n_wrapped;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_WINDOW_LENGTH:     r_window_length <= i_cfg_data[WL_W-1:0];
                    REG_CHANNEL_COUNT:     r_channel_count <= i_cfg_data[CNT_W-1:0];
                    REG_STATE_COUNT:       r_state_count   <= i_cfg_data[CNT_W-1:0];
                    REG_DISTURBANCE_COUNT: r_dist_count    <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/wae_back.sv
module wae_back #(
    parameter int WINDOW_MAX   = wae_pkg::WINDOW_MAX_DEF,
    parameter int MAX_CHANNELS = wae_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = wae_pkg::SAMPLE_WIDTH_DEF,
    parameter int ITEM_W       = wae_pkg::item_width(wae_pkg::SAMPLE_WIDTH_DEF,
                                     wae_pkg::MAX_CHANNELS_DEF, wae_pkg::WINDOW_MAX_DEF),
    parameter int CH_W         = wae_pkg::ch_width(wae_pkg::MAX_CHANNELS_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_item_empty,
    input  logic [ITEM_W-1:0]              i_item,
    output logic                           o_item_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output logic [CH_W-1:0]                o_channel,
    output logic signed [SAMPLE_WIDTH-1:0] o_estimate,
    output logic signed [SAMPLE_WIDTH:0]   o_disturbance,
    output logic                           o_disturbance_valid,
    output logic                           o_last_of_vector
);
    import wae_pkg::*;

    localparam int POS_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = SAMPLE_WIDTH + $clog2(WINDOW_MAX) + 1;
    localparam int DCNT_W    = $clog2(SUM_W + 1);
    localparam int ADDR_W    = POS_W + CH_W;
    localparam int MEM_DEPTH = WINDOW_MAX * (2 ** CH_W);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [CH_W-1:0]                ch;
        logic [POS_W-1:0]               pos;
        logic [LEN_W-1:0]               len;
        logic                           state_v;
        logic                           dist_v;
        logic                           last;
        logic                           old_valid;
    } t_item;

    t_back_state r_state, n_state;
    t_item       r_item;

    logic signed [SAMPLE_WIDTH-1:0] r_window [MEM_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rd;
    logic signed [SUM_W-1:0]        r_sums [MAX_CHANNELS];
    logic [SUM_W-1:0]               r_dvd;
    logic [LEN_W-1:0]               r_rem;
    logic                           r_neg;
    logic [DCNT_W-1:0]              r_cnt;

    logic [ADDR_W-1:0]              addr;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic signed [SUM_W-1:0]        new_sum;
    logic [SUM_W-1:0]               new_mag;
    logic [LEN_W:0]                 trial;
    logic                           q_bit;
    logic [LEN_W-1:0]               rem_next;
    logic [SUM_W-1:0]               est_full;

    assign addr = {r_item.pos, r_item.ch};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (!i_item_empty) n_state = BK_READ;
            BK_READ:  n_state = BK_ACCUM;
            BK_ACCUM: n_state = BK_DIV;
            BK_DIV:   if (r_cnt == DCNT_W'(1)) n_state = BK_EMIT;
            BK_EMIT:  if (!i_res_full) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            BK_IDLE:  o_item_pop = ~i_item_empty;
            BK_EMIT:  o_res_push = ~i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Replace the oldest sample in the running sum
    always_comb begin
        old_sample = r_item.old_valid ? r_rd : '0;
        new_sum    = r_sums[r_item.ch] + SUM_W'(r_item.sample) - SUM_W'(old_sample);
        new_mag    = new_sum[SUM_W-1] ? SUM_W'(0) - new_sum : new_sum;
    end

    // One restoring divide step per cycle
    always_comb begin
        trial    = {r_rem, r_dvd[SUM_W-1]};
        q_bit    = (trial >= {1'b0, r_item.len});
        rem_next = q_bit ? LEN_W'(trial - {1'b0, r_item.len}) : trial[LEN_W-1:0];
    end

    // Result fields
    always_comb begin
        est_full            = r_neg ? SUM_W'(0) - r_dvd : r_dvd;
        o_channel           = r_item.ch;
        o_estimate          = r_item.state_v ? est_full[SAMPLE_WIDTH-1:0] : '0;
        o_disturbance       = r_item.dist_v ?
                              (SAMPLE_WIDTH+1)'(r_item.sample) - (SAMPLE_WIDTH+1)'(o_estimate)
                              : '0;
        o_disturbance_valid = r_item.dist_v;
        o_last_of_vector    = r_item.last;
    end

    // Hold the item and run the divider
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_item <= i_item;
        end
        if (r_state == BK_ACCUM) begin
            r_dvd <= new_mag;
            r_neg <= new_sum[SUM_W-1];
            r_rem <= '0;
            r_cnt <= DCNT_W'(SUM_W);
        end else if (r_state == BK_DIV) begin
            r_dvd <= {r_dvd[SUM_W-2:0], q_bit};
            r_rem <= rem_next;
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    // Running sums, cleared with the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
        end else if (r_state == BK_ACCUM) begin
            r_sums[r_item.ch] <= new_sum;
        end
    end

    // Window store: read the slot, then overwrite it
    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_rd <= r_window[addr];
        end
        if (r_state == BK_ACCUM) begin
            r_window[addr] <= r_item.sample;
        end
    end

endmodule

// File: hw/rtl/windowed_average_estimator.sv
// Multichannel moving-average estimator. Samples (signed Q8.8) enter through push/full
// one channel at a time, channels in order; each produces one result on the output
// queue (empty/pop) with the channel, the truncated window average as estimate, and the
// sample minus that estimate as disturbance (each zero on channels beyond the state or
// disturbance count). The back end takes one item at a time: one window store read,
// one sum update, then a restoring divide by the window length at one quotient bit per
// cycle. Two-entry queues sit before and after the back end, so a few samples may be
// pushed and results left waiting without stalling the other side. Configuration
// writes are always ready and must be issued only while no item is in flight; a write
// to window_length or channel_count restarts the window with all-zero history. No
// clearing pass is needed after reset: slots not yet written since the last restart
// read as zero.
module windowed_average_estimator #(
    parameter int WINDOW_MAX   = wae_pkg::WINDOW_MAX_DEF,
    parameter int MAX_CHANNELS = wae_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = wae_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [wae_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [wae_pkg::CFG_DATA_W-1:0]            i_cfg_data,
    input  logic                                      push,
    output logic                                      full,
    input  logic signed [SAMPLE_WIDTH-1:0]            i_sample,
    output logic                                      empty,
    input  logic                                      pop,
    output logic [wae_pkg::ch_width(MAX_CHANNELS)-1:0] o_channel,
    output logic signed [SAMPLE_WIDTH-1:0]            o_estimate,
    output logic signed [SAMPLE_WIDTH:0]              o_disturbance,
    output logic                                      o_disturbance_valid,
    output logic                                      o_last_of_vector
);
    import wae_pkg::*;

    localparam int CH_W   = ch_width(MAX_CHANNELS);
    localparam int ITEM_W = item_width(SAMPLE_WIDTH, MAX_CHANNELS, WINDOW_MAX);
    localparam int RES_W  = CH_W + 2 * SAMPLE_WIDTH + 3;

    logic                           item_push, item_full, item_pop, item_empty;
    logic [ITEM_W-1:0]              item_wr, item_rd;
    logic                           clear;
    logic                           res_push, res_full;
    logic [RES_W-1:0]               res_wr, res_rd;
    logic [CH_W-1:0]                bk_channel;
    logic signed [SAMPLE_WIDTH-1:0] bk_estimate;
    logic signed [SAMPLE_WIDTH:0]   bk_disturbance;
    logic                           bk_disturbance_valid;
    logic                           bk_last;

    wae_front #(
        .WINDOW_MAX   (WINDOW_MAX),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ITEM_W       (ITEM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_sample    (i_sample),
        .o_full      (full),
        .i_item_full (item_full),
        .o_item_push (item_push),
        .o_item      (item_wr),
        .o_clear     (clear)
    );

    wae_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (item_wr),
        .o_full  (item_full),
        .i_pop   (item_pop),
        .o_data  (item_rd),
        .o_empty (item_empty)
    );

    wae_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ITEM_W       (ITEM_W),
        .CH_W         (CH_W)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_clear             (clear),
        .i_item_empty        (item_empty),
        .i_item              (item_rd),
        .o_item_pop          (item_pop),
        .i_res_full          (res_full),
        .o_res_push          (res_push),
        .o_channel           (bk_channel),
        .o_estimate          (bk_estimate),
        .o_disturbance       (bk_disturbance),
        .o_disturbance_valid (bk_disturbance_valid),
        .o_last_of_vector    (bk_last)
    );

    // Pack results into the output queue and unpack at its head
    assign res_wr = {bk_channel, bk_estimate, bk_disturbance, bk_disturbance_valid, bk_last};
    assign {o_channel, o_estimate, o_disturbance, o_disturbance_valid, o_last_of_vector} =
        res_rd;

    wae_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wr),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rd),
        .o_empty (empty)
    );

endmodule

// File: hw/rtl/wae_checker.sv
module wae_checker #(
    parameter int SAMPLE_WIDTH = wae_pkg::SAMPLE_WIDTH_DEF,
    parameter int CH_W         = wae_pkg::ch_width(wae_pkg::MAX_CHANNELS_DEF)
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic [CH_W-1:0]                o_channel,
    input logic signed [SAMPLE_WIDTH-1:0] o_estimate,
    input logic signed [SAMPLE_WIDTH:0]   o_disturbance,
    input logic                           o_disturbance_valid,
    input logic                           o_last_of_vector
);

    // No result may be waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // A disturbance marked invalid must read as zero
    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_disturbance_valid) |-> (o_disturbance == '0))
        else $error("invalid disturbance is not zero");

    // A waiting result is not dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

    // A waiting result holds its payload
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_channel) && $stable(o_estimate) &&
                              $stable(o_disturbance) && $stable(o_disturbance_valid) &&
                              $stable(o_last_of_vector)))
        else $error("waiting result changed");

endmodule

bind windowed_average_estimator wae_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CH_W         (CH_W)
) u_wae_checker (.*);
